/* sv/swmdb_pkg.sv */
package swmdb_pkg;

	localparam int LANES        = 8;
	localparam int MODULE_COUNT = 16;
	localparam int GROUP_W      = 5;
	localparam int CNT_W        = 8;
	localparam int ATTACK_W     = 7;
	localparam int LEVEL_W      = LANES;
	localparam int ID_W         = 8;
	localparam int LANE_IDX_W   = $clog2(LANES);
	localparam int DEPTH        = 17;
	localparam int SWITCH_COUNT = 136;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 8;

	localparam logic [GROUP_W-1:0]  MASTER_GROUP = GROUP_W'(16);
	localparam logic [CNT_W-1:0]    CNT_RESET    = CNT_W'(8);
	localparam logic [ATTACK_W-1:0] ATTACK_RESET = ATTACK_W'(8);
	localparam logic [LEVEL_W-1:0]  MASK_RESET   = LEVEL_W'(3);

	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MASK   = CFG_IDX_W'(1);

	typedef struct packed {
		logic               en;
		logic [GROUP_W-1:0] group;
		logic               active;
	} lane_req_t;

	typedef struct packed {
		logic evt;
		logic released;
	} lane_res_t;

	typedef struct packed {
		logic               s1_valid;
		logic               done;
		logic [LEVEL_W-1:0] mask;
	} merge_stat_t;

endpackage

/* sv/swmdb_in_if.sv */
interface swmdb_in_if;
	logic                          valid;
	logic                          ready;
	logic [swmdb_pkg::GROUP_W-1:0] group;
	logic [swmdb_pkg::LEVEL_W-1:0] levels;

	modport source (output valid, group, levels, input ready);
	modport sink (input valid, group, levels, output ready);
endinterface

/* sv/swmdb_out_if.sv */
interface swmdb_out_if;
	logic                       valid;
	logic                       ready;
	logic [swmdb_pkg::ID_W-1:0] switch_id;
	logic                       released;
	logic                       last;

	modport source (output valid, switch_id, released, last, input ready);
	modport sink (input valid, switch_id, released, last, output ready);
endinterface

/* sv/swmdb_cfg_if.sv */
interface swmdb_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [swmdb_pkg::CFG_IDX_W-1:0]  index;
	logic [swmdb_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/switch_matrix_debounce_events.sv */
// Flow: an accepted group's events are registered in stage 1, then in the stage-2 mask, and leave one at a time.
// Throughput: one group per cycle while stage 1 holds no group with events waiting; a group
// with events (up to 8) waits for the single output serializer behind the eight counter lanes.
// Reset: arst_n clears all counters to 8 (switch off), attack_count to 8 and
// master_mask to 3; no event pending after reset.
module switch_matrix_debounce_events (
	input  logic        clk,
	input  logic        arst_n,
	swmdb_in_if.sink    items,
	swmdb_out_if.source events,
	swmdb_cfg_if.sink   cfg
);

	logic [swmdb_pkg::ATTACK_W-1:0] attack_count_q;
	logic [swmdb_pkg::LEVEL_W-1:0]  master_mask_q;

	swmdb_pkg::lane_req_t   lane_req [swmdb_pkg::LANES];
	swmdb_pkg::lane_res_t   lane_res [swmdb_pkg::LANES];
	swmdb_pkg::merge_stat_t stat;

	logic [swmdb_pkg::LEVEL_W-1:0] evt;
	logic [swmdb_pkg::LEVEL_W-1:0] rel;
	logic [swmdb_pkg::LEVEL_W-1:0] lvl;
	logic                          accept;
	logic                          is_master;

	assign cfg.ready    = 1'b1;
	assign items.ready  = !stat.s1_valid || stat.done;
	assign accept       = items.valid && items.ready;
	assign is_master    = (items.group == swmdb_pkg::MASTER_GROUP);
	assign lvl          = is_master ? (items.levels & master_mask_q) : items.levels;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_count_q <= swmdb_pkg::ATTACK_RESET;
			master_mask_q  <= swmdb_pkg::MASK_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				swmdb_pkg::CFG_ATTACK: attack_count_q <= cfg.data[swmdb_pkg::ATTACK_W-1:0];
				swmdb_pkg::CFG_MASK:   master_mask_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < swmdb_pkg::LANES; i++) begin : g_lane
		logic present;
		assign present = is_master || (items.group < swmdb_pkg::MASTER_GROUP
			&& 5'({items.group[3], 3'(i)}) < 5'(swmdb_pkg::MODULE_COUNT));
		assign lane_req[i].en     = accept && present;
		assign lane_req[i].group  = items.group;
		assign lane_req[i].active = !lvl[i];

		swmdb_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.req          (lane_req[i]),
			.attack_count (attack_count_q),
			.res          (lane_res[i])
		);

		assign evt[i] = lane_res[i].evt;
		assign rel[i] = lane_res[i].released;
	end

	swmdb_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.group  (items.group),
		.evt    (evt),
		.rel    (rel),
		.stat   (stat),
		.events (events)
	);

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.ready && !events.last |=> events.valid)
		else $error("event stream ended without last");

	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid |-> events.switch_id < 8'(swmdb_pkg::SWITCH_COUNT))
		else $error("switch id out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && evt != '0 |=> stat.s1_valid)
		else $error("accepted group with events was lost");

	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.last |-> $onehot(stat.mask))
		else $error("last flagged with events pending");

endmodule

/* sv/swmdb_lane.sv */
module swmdb_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swmdb_pkg::lane_req_t                req,
	input  logic [swmdb_pkg::ATTACK_W-1:0]      attack_count,
	output swmdb_pkg::lane_res_t                res
);

	logic [swmdb_pkg::CNT_W-1:0] cnt_q [swmdb_pkg::DEPTH];
	logic [swmdb_pkg::CNT_W-1:0] cur;
	logic [swmdb_pkg::CNT_W-1:0] dec;
	logic [swmdb_pkg::CNT_W-1:0] nxt;
	logic                        wr;

	assign cur = (req.group <= swmdb_pkg::MASTER_GROUP) ? cnt_q[req.group]
		: swmdb_pkg::CNT_RESET;
	assign dec = cur - swmdb_pkg::CNT_W'(1);

	always_comb begin
		wr           = 1'b0;
		nxt          = cur;
		res.evt      = 1'b0;
		res.released = 1'b0;
		if (req.en && req.active && !cur[swmdb_pkg::CNT_W-1]) begin
			wr      = 1'b1;
			nxt     = dec;
			res.evt = dec[swmdb_pkg::CNT_W-1];
		end else if (req.en && !req.active && cur[swmdb_pkg::CNT_W-1]) begin
			wr           = 1'b1;
			nxt          = {1'b0, attack_count};
			res.evt      = 1'b1;
			res.released = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < swmdb_pkg::DEPTH; i++) begin
				cnt_q[i] <= swmdb_pkg::CNT_RESET;
			end
		end else if (wr) begin
			cnt_q[req.group] <= nxt;
		end
	end

endmodule

/* sv/swmdb_merge.sv */
module swmdb_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic [swmdb_pkg::GROUP_W-1:0]       group,
	input  logic [swmdb_pkg::LEVEL_W-1:0]       evt,
	input  logic [swmdb_pkg::LEVEL_W-1:0]       rel,
	output swmdb_pkg::merge_stat_t              stat,
	swmdb_out_if.source                         events
);

	logic                          s1_valid_s1;
	logic [swmdb_pkg::GROUP_W-1:0] group_s1;
	logic [swmdb_pkg::LEVEL_W-1:0] evt_s1;
	logic [swmdb_pkg::LEVEL_W-1:0] rel_s1;

	logic [swmdb_pkg::GROUP_W-1:0] group_s2;
	logic [swmdb_pkg::LEVEL_W-1:0] mask_s2;
	logic [swmdb_pkg::LEVEL_W-1:0] rel_s2;

	logic [swmdb_pkg::LEVEL_W-1:0]    rest;
	logic [swmdb_pkg::LANE_IDX_W-1:0] idx;
	logic                             fire;
	logic                             done;

	assign rest = mask_s2 & (mask_s2 - swmdb_pkg::LEVEL_W'(1));
	assign fire = events.valid && events.ready;
	assign done = (mask_s2 == '0) || (fire && rest == '0);

	always_comb begin
		idx = '0;
		for (int i = swmdb_pkg::LANES - 1; i >= 0; i--) begin
			if (mask_s2[i]) begin
				idx = swmdb_pkg::LANE_IDX_W'(i);
			end
		end
	end

	assign events.valid     = (mask_s2 != '0);
	assign events.released  = rel_s2[idx];
	assign events.last      = (rest == '0);
	assign events.switch_id = (group_s2 == swmdb_pkg::MASTER_GROUP)
		? {1'b1, 4'b0000, idx}
		: {1'b0, group_s2[3], idx, group_s2[2:0]};

	assign stat.s1_valid = s1_valid_s1;
	assign stat.done     = done;
	assign stat.mask     = mask_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			mask_s2     <= '0;
		end else begin
			if (load && evt != '0) begin
				s1_valid_s1 <= 1'b1;
			end else if (done) begin
				s1_valid_s1 <= 1'b0;
			end
			if (done) begin
				mask_s2 <= s1_valid_s1 ? evt_s1 : '0;
			end else if (fire) begin
				mask_s2 <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			group_s1 <= group;
			evt_s1   <= evt;
			rel_s1   <= rel;
		end
		if (done) begin
			group_s2 <= group_s1;
			rel_s2   <= rel_s1;
		end
	end

endmodule

/* verif/switch_matrix_debounce_events_tb.sv */
module switch_matrix_debounce_events_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swmdb_pkg::*;

	localparam int MASTER_BASE = SWITCH_COUNT - LANES;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [ID_W-1:0] switch_id;
		logic            released;
		logic            last;
	} switch_event_t;

	class debounce_tracker;
		logic [CNT_W-1:0]    counters [SWITCH_COUNT];
		logic [ATTACK_W-1:0] attack;
		logic [LEVEL_W-1:0]  mask;
		switch_event_t       pending_events [$];
		switch_event_t       burst [$];
		int                  faults;

		function new();
			foreach (counters[i])
				counters[i] = CNT_RESET;
			attack = ATTACK_RESET;
			mask = MASK_RESET;
			faults = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_ATTACK)
				attack = data[ATTACK_W-1:0];
			else if (idx == CFG_MASK)
				mask = data[LEVEL_W-1:0];
		endfunction

		function void step_switch(int idx, logic active);
			logic [CNT_W-1:0] c;
			switch_event_t ev;
			c = counters[idx];
			ev.switch_id = ID_W'(idx);
			ev.last = 1'b0;
			if (active && !c[CNT_W-1]) begin
				c = c - 1'b1;
				counters[idx] = c;
				if (c[CNT_W-1]) begin
					ev.released = 1'b0;
					burst.push_back(ev);
				end
			end else if (!active && c[CNT_W-1]) begin
				counters[idx] = CNT_W'(attack);
				ev.released = 1'b1;
				burst.push_back(ev);
			end
		endfunction

		// one accepted request: predicts the events of this scanned group
		function void scan_group(logic [GROUP_W-1:0] grp, logic [LEVEL_W-1:0] lv);
			int mdl;
			burst.delete();
			if (grp == MASTER_GROUP) begin
				lv = lv & mask;
				for (int i = 0; i < LANES; i++)
					step_switch(MASTER_BASE + i, !lv[i]);
			end else if (grp < MASTER_GROUP) begin
				for (int i = 0; i < LANES; i++) begin
					mdl = int'(grp >> 3) * LANES + i;
					if (mdl < MODULE_COUNT)
						step_switch(mdl * LANES + int'(grp[2:0]), !lv[i]);
				end
			end
			if (burst.size() > 0)
				burst[burst.size()-1].last = 1'b1;
			foreach (burst[i])
				pending_events.push_back(burst[i]);
		endfunction

		function void match_event(logic [ID_W-1:0] id, logic rel, logic lst);
			switch_event_t want;
			if (pending_events.size() == 0) begin
				faults++;
				$display("%0t: event with none expected, actual id %0d released %0b last %0b",
					$time, id, rel, lst);
				return;
			end
			want = pending_events.pop_front();
			if (want.switch_id !== id) begin
				faults++;
				$display("%0t: switch_id expected %0d actual %0d", $time, want.switch_id, id);
			end
			if (want.released !== rel) begin
				faults++;
				$display("%0t: released expected %0b actual %0b (id %0d)",
					$time, want.released, rel, want.switch_id);
			end
			if (want.last !== lst) begin
				faults++;
				$display("%0t: last expected %0b actual %0b (id %0d)",
					$time, want.last, lst, want.switch_id);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	swmdb_in_if  items ();
	swmdb_out_if events ();
	swmdb_cfg_if cfg ();

	switch_matrix_debounce_events DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items.sink),
		.events (events.source),
		.cfg    (cfg.sink)
	);

	debounce_tracker tracker = new();

	int gap_pct;
	int stall_pct;
	int idle_cycles;
	int cur_attack;

	always begin
		clk = 1'b0;
		#5ns;
		clk = 1'b1;
		#5ns;
	end

	// output side backpressure
	initial begin
		int stall;
		stall = 0;
		events.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0)
				stall--;
			else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
				stall = $urandom_range(1, 14);
			events.ready <= (stall == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (events.valid && events.ready)
				tracker.match_event(events.switch_id, events.released, events.last);
			if (items.valid && items.ready)
				tracker.scan_group(items.group, items.levels);
			if (cfg.valid && cfg.ready)
				tracker.write_reg(cfg.index, cfg.data);
			if ((events.valid && events.ready) || (items.valid && items.ready)
					|| (cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_group(input logic [GROUP_W-1:0] grp, input logic [LEVEL_W-1:0] lv);
		int gap;
		gap = 0;
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid <= 1'b1;
		items.group <= grp;
		items.levels <= lv;
		do @(posedge clk); while (!items.ready);
	endtask

	task automatic wait_quiet();
		items.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_events.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] attack_data,
			input logic [CFG_DATA_W-1:0] mask_data);
		cfg.valid <= 1'b1;
		cfg.index <= CFG_ATTACK;
		cfg.data <= attack_data;
		do @(posedge clk); while (!cfg.ready);
		cfg.index <= CFG_MASK;
		cfg.data <= mask_data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_attack = int'(attack_data[ATTACK_W-1:0]);
	endtask

	// hold a level pattern on one group for a random run, at times long enough to press, then release or break off
	task automatic random_run(input int budget);
		int n;
		int len;
		logic [GROUP_W-1:0] grp;
		logic [LEVEL_W-1:0] base;
		logic [LEVEL_W-1:0] lv;
		n = 0;
		while (n < budget) begin
			if ($urandom_range(0, 9) == 0) begin
				send_group(GROUP_W'($urandom_range(17, 31)), LEVEL_W'($urandom));
			end else begin
				grp = GROUP_W'($urandom_range(0, 16));
				base = ($urandom_range(0, 3) == 0) ? '0 : LEVEL_W'($urandom);
				len = $urandom_range(1, cur_attack + 4);
				for (int k = 0; k < len; k++) begin
					lv = base;
					if ($urandom_range(0, 5) == 0)
						lv[$urandom_range(0, LEVEL_W-1)] ^= 1'b1;
					send_group(grp, lv);
					n++;
				end
				if ($urandom_range(0, 3) != 0) begin
					lv = ($urandom_range(0, 1) == 0) ? '1 : ~base;
					send_group(grp, lv);
					n++;
				end
			end
		end
	endtask

	initial begin
		int phase;
		logic [CFG_DATA_W-1:0] adata;
		arst_n = 1'b0;
		items.valid <= 1'b0;
		items.group <= '0;
		items.levels <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_ATTACK;
		cfg.data <= '0;
		gap_pct = 0;
		stall_pct = 0;
		idle_cycles = 0;
		cur_attack = int'(ATTACK_RESET);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unused groups, masked master bits, full row press, partial release
		gap_pct = 25;
		stall_pct = 25;
		send_group(GROUP_W'(17), 8'h00);
		send_group(GROUP_W'(31), 8'hFF);
		send_group(MASTER_GROUP, 8'hFF);
		repeat (9) send_group(GROUP_W'(0), 8'h00);
		send_group(GROUP_W'(0), 8'h0F);
		send_group(GROUP_W'(15), 8'h55);
		send_group(GROUP_W'(8), 8'hAA);
		wait_quiet();

		// zero attack count (bit 7 of the data is dropped), full master mask
		configure(8'h80, 8'hFF);
		send_group(GROUP_W'(0), 8'hFF);
		send_group(GROUP_W'(0), 8'h00);
		send_group(MASTER_GROUP, 8'h5A);
		wait_quiet();

		// largest attack count, empty master mask
		configure(8'h7F, 8'h00);
		send_group(GROUP_W'(0), 8'hFF);
		send_group(MASTER_GROUP, 8'hFF);
		wait_quiet();

		phase = 0;
		while (phase < 4) begin
			adata[ATTACK_W-1:0] = ($urandom_range(0, 9) == 0) ?
				ATTACK_W'($urandom_range(7, 24)) : ATTACK_W'($urandom_range(0, 6));
			adata[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
			configure(adata, CFG_DATA_W'($urandom));
			if (phase >= 3) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
			end
			random_run(32);
			wait_quiet();
			phase++;
		end

		repeat (10) @(posedge clk);
		if (tracker.faults == 0 && tracker.pending_events.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
